/* hdl/swfr_pkg.sv */
// Shared types and constants for the sliding-window fast-retransmit sender.
// Used by swfr_engine and the top level; depends on nothing.
`timescale 1ns / 1ps

package swfr_pkg;

	// Fixed field widths of the event and result words
	localparam int PAYLOAD_W = 64;
	localparam int ID_W      = 3;
	localparam int DUP_W     = 3;

	// Stream word widths; the data words are padded to whole bytes
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 80;

	// Default configuration
	localparam int WINDOW_DEF       = 4;
	localparam int SEQ_BITS_DEF     = 3;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Duplicate ACK counter values
	localparam logic [DUP_W-1:0] DUP_MAX       = 3'd7;
	localparam logic [DUP_W-1:0] DUP_FAST      = 3'd3;
	localparam logic [DUP_W-1:0] DUP_AFTER_ACK = 3'd1;

	// Event kinds
	typedef enum logic [1:0] {
		FUNC_SEND    = 2'd0,
		FUNC_ACK     = 2'd1,
		FUNC_TIMEOUT = 2'd2
	} func_t;

	typedef struct packed {
		func_t                 func;
		logic [PAYLOAD_W-1:0]  payload;
		logic [ID_W-1:0]       ack_num;
		logic                  ack_checksum_ok;
		logic [ID_W-1:0]       expired_timer_id;
	} event_t;

	typedef struct packed {
		logic                  accepted;
		logic                  pkt_valid;
		logic [ID_W-1:0]       pkt_seq;
		logic [PAYLOAD_W-1:0]  pkt_payload;
		logic                  timer_start;
		logic [ID_W-1:0]       timer_start_id;
		logic                  timer_stop;
		logic [ID_W-1:0]       timer_stop_id;
	} result_t;

endpackage

/* hdl/swfr_engine.sv */
// Sender state, window payload store and per-event decision logic.
// Depends on swfr_pkg; result is combinational from state and the event word.
`timescale 1ns / 1ps

module swfr_engine #(
	parameter int WINDOW       = swfr_pkg::WINDOW_DEF,
	parameter int SEQ_BITS     = swfr_pkg::SEQ_BITS_DEF,
	parameter int PAYLOAD_BITS = swfr_pkg::PAYLOAD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	input  swfr_pkg::event_t  ev,
	output swfr_pkg::result_t res
);

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = IDX_W + 1;
	// residue lost when a sequence number wraps past 2^SEQ_BITS
	localparam int WRAP_REM = (2 ** SEQ_BITS) % WINDOW;
	localparam logic [SEQ_BITS-1:0] SEQ_MAX = SEQ_BITS'((2 ** SEQ_BITS) - 1);
	localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);
	localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(WINDOW - 1);
	localparam logic [IDX_W-1:0]    IDX_ONE  = IDX_W'(1);
	localparam logic [SUM_W-1:0]    SUM_WIN  = SUM_W'(WINDOW);
	localparam logic [SUM_W-1:0]    SUM_REM  = SUM_W'(WRAP_REM);

	// State
	logic [SEQ_BITS-1:0]     base_q, next_q, timer_q;
	logic [swfr_pkg::DUP_W-1:0] dup_q;
	logic [IDX_W-1:0]        base_idx_q, next_idx_q;
	logic [WINDOW-1:0]       valid_q;
	logic [PAYLOAD_BITS-1:0] mem [WINDOW];
	logic [PAYLOAD_BITS-1:0] oldest_q;

	// Next state
	logic [SEQ_BITS-1:0]     base_d, next_d, timer_d;
	logic [swfr_pkg::DUP_W-1:0] dup_d;
	logic [IDX_W-1:0]        base_idx_d, next_idx_d;
	logic                    wr_en;

	// Decode helpers
	logic [SEQ_BITS-1:0]     ack, fill, adist;
	logic [PAYLOAD_BITS-1:0] pay;
	logic                    win_open, in_win;
	logic [SUM_W-1:0]        t_sum, t_adj, t_red;
	logic [IDX_W-1:0]        ack_idx, ridx;

	assign ack      = SEQ_BITS'(ev.ack_num);
	assign pay      = PAYLOAD_BITS'(ev.payload);
	assign fill     = next_q - base_q;
	assign adist    = ack - base_q;
	assign win_open = 32'(fill) < 32'(WINDOW);
	assign in_win   = 32'(adist) < 32'(WINDOW);

	// Store slot of the ACK number (ack mod WINDOW), from the base slot.
	// Only meaningful when in_win, so adist < WINDOW and t_sum < 2*WINDOW.
	always_comb begin
		t_sum = SUM_W'(base_idx_q) + SUM_W'(adist);
		if (ack < base_q) begin
			// ACK number wrapped past zero
			if (t_sum >= SUM_REM) begin
				t_adj = t_sum - SUM_REM;
			end else begin
				t_adj = t_sum + SUM_WIN - SUM_REM;
			end
		end else begin
			t_adj = t_sum;
		end
		if (t_adj >= SUM_WIN) begin
			t_red = t_adj - SUM_WIN;
		end else begin
			t_red = t_adj;
		end
		ack_idx = IDX_W'(t_red);
	end

	// Event decision and next state
	always_comb begin
		base_d     = base_q;
		next_d     = next_q;
		timer_d    = timer_q;
		dup_d      = dup_q;
		base_idx_d = base_idx_q;
		next_idx_d = next_idx_q;
		wr_en      = 1'b0;
		res        = '0;
		unique case (ev.func)
			swfr_pkg::FUNC_SEND: begin
				if (win_open) begin
					wr_en           = 1'b1;
					res.accepted    = 1'b1;
					res.pkt_valid   = 1'b1;
					res.pkt_seq     = swfr_pkg::ID_W'(next_q);
					res.pkt_payload = swfr_pkg::PAYLOAD_W'(pay);
					if (base_q == next_q) begin
						timer_d            = base_q;
						res.timer_start    = 1'b1;
						res.timer_start_id = swfr_pkg::ID_W'(base_q);
					end
					next_d = next_q + SEQ_ONE;
					if (next_q == SEQ_MAX || next_idx_q == IDX_LAST) begin
						next_idx_d = '0;
					end else begin
						next_idx_d = next_idx_q + IDX_ONE;
					end
				end
			end
			swfr_pkg::FUNC_ACK: begin
				if (ev.ack_checksum_ok) begin
					if (in_win) begin
						dup_d  = swfr_pkg::DUP_AFTER_ACK;
						base_d = ack + SEQ_ONE;
						if (ack == SEQ_MAX || ack_idx == IDX_LAST) begin
							base_idx_d = '0;
						end else begin
							base_idx_d = ack_idx + IDX_ONE;
						end
						if (base_d == next_q) begin
							res.timer_stop    = 1'b1;
							res.timer_stop_id = swfr_pkg::ID_W'(timer_q);
						end
					end else if (dup_q < swfr_pkg::DUP_MAX) begin
						dup_d = dup_q + swfr_pkg::DUP_W'(1);
						// duplicate count reaching DUP_FAST: fast retransmit of the oldest word
						if (dup_d == swfr_pkg::DUP_FAST) begin
							res.pkt_valid   = 1'b1;
							res.pkt_seq     = swfr_pkg::ID_W'(base_q);
							res.pkt_payload = swfr_pkg::PAYLOAD_W'(oldest_q);
						end
					end
				end
			end
			swfr_pkg::FUNC_TIMEOUT: begin
				res.pkt_valid      = 1'b1;
				res.pkt_seq        = swfr_pkg::ID_W'(base_q);
				res.pkt_payload    = swfr_pkg::PAYLOAD_W'(oldest_q);
				timer_d            = base_q;
				res.timer_stop     = 1'b1;
				res.timer_stop_id  = ev.expired_timer_id;
				res.timer_start    = 1'b1;
				res.timer_start_id = swfr_pkg::ID_W'(base_q);
			end
			default: begin
			end
		endcase
	end

	// Slot of the oldest outstanding payload after this edge
	assign ridx = ev_valid ? base_idx_d : base_idx_q;

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			next_q     <= '0;
			timer_q    <= '0;
			dup_q      <= '0;
			base_idx_q <= '0;
			next_idx_q <= '0;
		end else if (ev_valid) begin
			base_q     <= base_d;
			next_q     <= next_d;
			timer_q    <= timer_d;
			dup_q      <= dup_d;
			base_idx_q <= base_idx_d;
			next_idx_q <= next_idx_d;
		end
	end

	// Slot valid bits; an unwritten slot reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ev_valid && wr_en) begin
			valid_q[next_idx_q] <= 1'b1;
		end
	end

	// Payload store write port
	always_ff @(posedge clk) begin
		if (ev_valid && wr_en) begin
			mem[next_idx_q] <= pay;
		end
	end

	// Registered read of the oldest slot, with bypass of a same-cycle write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
		end else if (ev_valid && wr_en && next_idx_q == ridx) begin
			oldest_q <= pay;
		end else if (valid_q[ridx]) begin
			oldest_q <= mem[ridx];
		end else begin
			oldest_q <= '0;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(base_idx_q) < 32'(WINDOW)) && (32'(next_idx_q) < 32'(WINDOW)))
		else $error("store slot index out of range");

	a_send_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && res.accepted) |=> (next_q == $past(next_q) + SEQ_ONE))
		else $error("accepted send did not advance next sequence");

	a_accept_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && res.accepted) |-> (res.pkt_valid && ev.func == swfr_pkg::FUNC_SEND))
		else $error("accepted flag without an emitted send");

	a_dup_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_valid && ev.func == swfr_pkg::FUNC_ACK && ev.ack_checksum_ok && in_win)
		|=> (dup_q == swfr_pkg::DUP_AFTER_ACK))
		else $error("in-window ACK did not reset duplicate count");
`endif

endmodule

/* hdl/sliding_window_fast_retransmit_sender_core.sv */
// Each result word is registered when its event word is taken, into the output register or the skid entry.
// Throughput: one event word per cycle; a two-entry output buffer keeps s_tready high
// while one finished result waits, so the input stalls only when both entries are full.
// Reset (arst_n low) clears sequence state, duplicate count and store valid bits at once;
// an unwritten store slot reads as zero and no clearing pass is needed.
// Top level of the sender; depends on swfr_pkg and swfr_engine.
`timescale 1ns / 1ps

module sliding_window_fast_retransmit_sender_core #(
	parameter int WINDOW       = swfr_pkg::WINDOW_DEF,
	parameter int SEQ_BITS     = swfr_pkg::SEQ_BITS_DEF,
	parameter int PAYLOAD_BITS = swfr_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// payload[63:0], ack_num[66:64], ack_checksum_ok[67], expired_timer_id[70:68], zero[71]
	input  logic [swfr_pkg::S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [swfr_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// accepted[0], pkt_valid[1], pkt_seq[4:2], pkt_payload[68:5], timer_start[69],
	// timer_start_id[72:70], timer_stop[73], timer_stop_id[76:74], zero[79:77]
	output logic [swfr_pkg::M_TDATA_W-1:0] m_tdata
);

	swfr_pkg::event_t  ev;
	swfr_pkg::result_t res;
	swfr_pkg::result_t out_q, skid_q;
	logic              out_v_q, skid_v_q;
	logic              push, pop;

	// Unpack the event word
	always_comb begin
		ev.func             = swfr_pkg::func_t'(s_tuser);
		ev.payload          = s_tdata[63:0];
		ev.ack_num          = s_tdata[66:64];
		ev.ack_checksum_ok  = s_tdata[67];
		ev.expired_timer_id = s_tdata[70:68];
	end

	assign s_tready = !skid_v_q;
	assign push     = s_tvalid && s_tready;
	assign pop      = out_v_q && m_tready;

	swfr_engine #(
		.WINDOW      (WINDOW),
		.SEQ_BITS    (SEQ_BITS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.ev_valid(push),
		.ev      (ev),
		.res     (res)
	);

	// Output buffer control: main register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// Output buffer data
	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	// Pack the result word
	assign m_tvalid = out_v_q;
	always_comb begin
		m_tdata        = '0;
		m_tdata[0]     = out_q.accepted;
		m_tdata[1]     = out_q.pkt_valid;
		m_tdata[4:2]   = out_q.pkt_seq;
		m_tdata[68:5]  = out_q.pkt_payload;
		m_tdata[69]    = out_q.timer_start;
		m_tdata[72:70] = out_q.timer_start_id;
		m_tdata[73]    = out_q.timer_stop;
		m_tdata[76:74] = out_q.timer_stop_id;
	end

endmodule

/* sim/swfr_checker.sv */
// Scoreboard for the sliding-window fast-retransmit sender: watches both stream
// channels, predicts every response word and compares it field by field.
// Depends on swfr_pkg only.
`timescale 1ns / 1ps

module swfr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// payload[63:0], ack_num[66:64], ack_checksum_ok[67], expired_timer_id[70:68], zero[71]
	input  logic [swfr_pkg::S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [swfr_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// accepted[0], pkt_valid[1], pkt_seq[4:2], pkt_payload[68:5], timer_start[69],
	// timer_start_id[72:70], timer_stop[73], timer_stop_id[76:74], zero[79:77]
	input  logic [swfr_pkg::M_TDATA_W-1:0] m_tdata,
	output int                             fail_count,
	output int                             outstanding,
	output int                             checked_count,
	output int                             refused_count,
	output int                             fast_resend_count
);

	localparam int WIN = swfr_pkg::WINDOW_DEF;

	// Shadow copy of the sender state
	logic [swfr_pkg::ID_W-1:0]      base_seq;
	logic [swfr_pkg::ID_W-1:0]      next_seq;
	logic [swfr_pkg::ID_W-1:0]      timer_id;
	logic [swfr_pkg::DUP_W-1:0]     dup_count;
	logic [swfr_pkg::PAYLOAD_W-1:0] slot_data [WIN];

	swfr_pkg::result_t expected_responses [$];

	// Work out the response word for one event and advance the shadow state
	task automatic predict_sender_response(input logic [1:0] fn,
			input logic [swfr_pkg::PAYLOAD_W-1:0] pay, input logic [swfr_pkg::ID_W-1:0] ack,
			input logic ok, input logic [swfr_pkg::ID_W-1:0] exp_id,
			output swfr_pkg::result_t r);
		logic [swfr_pkg::ID_W-1:0] span;
		r = '0;
		case (fn)
			swfr_pkg::FUNC_SEND: begin
				span = next_seq - base_seq;
				if (span < WIN) begin
					slot_data[next_seq % WIN] = pay;
					r.accepted    = 1'b1;
					r.pkt_valid   = 1'b1;
					r.pkt_seq     = next_seq;
					r.pkt_payload = pay;
					// first packet into an empty window arms the timer
					if (base_seq == next_seq) begin
						timer_id         = base_seq;
						r.timer_start    = 1'b1;
						r.timer_start_id = base_seq;
					end
					next_seq = next_seq + 1'b1;
				end else begin
					refused_count++;
				end
			end
			swfr_pkg::FUNC_ACK: begin
				if (ok) begin
					span = ack - base_seq;
					if (span < WIN) begin
						// cumulative ack, possibly for a number not yet sent
						dup_count = swfr_pkg::DUP_AFTER_ACK;
						base_seq  = ack + 1'b1;
						if (base_seq == next_seq) begin
							r.timer_stop    = 1'b1;
							r.timer_stop_id = timer_id;
						end
					end else if (dup_count < swfr_pkg::DUP_MAX) begin
						dup_count = dup_count + 1'b1;
						if (dup_count == swfr_pkg::DUP_FAST) begin
							r.pkt_valid   = 1'b1;
							r.pkt_seq     = base_seq;
							r.pkt_payload = slot_data[base_seq % WIN];
							fast_resend_count++;
						end
					end
				end
			end
			swfr_pkg::FUNC_TIMEOUT: begin
				// resend oldest even if window is empty, then re-arm
				r.pkt_valid      = 1'b1;
				r.pkt_seq        = base_seq;
				r.pkt_payload    = slot_data[base_seq % WIN];
				timer_id         = base_seq;
				r.timer_stop     = 1'b1;
				r.timer_stop_id  = exp_id;
				r.timer_start    = 1'b1;
				r.timer_start_id = base_seq;
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] want_v, got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want_v, got_v);
		end
	endtask

	// Response channel is compared before the event channel is predicted; since each
	// result word is registered, a word never answers the event taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		swfr_pkg::result_t want;
		swfr_pkg::result_t pred;
		if (!arst_n) begin
			base_seq  = '0;
			next_seq  = '0;
			timer_id  = '0;
			dup_count = '0;
			for (int i = 0; i < WIN; i++)
				slot_data[i] = '0;
			expected_responses.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				checked_count++;
				if (expected_responses.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected response word, expected none actual %0h",
						$time, m_tdata);
				end else begin
					want = expected_responses.pop_front();
					check_field("accepted", want.accepted, m_tdata[0]);
					check_field("pkt_valid", want.pkt_valid, m_tdata[1]);
					check_field("pkt_seq", want.pkt_seq, m_tdata[4:2]);
					check_field("pkt_payload", want.pkt_payload, m_tdata[68:5]);
					check_field("timer_start", want.timer_start, m_tdata[69]);
					check_field("timer_start_id", want.timer_start_id, m_tdata[72:70]);
					check_field("timer_stop", want.timer_stop, m_tdata[73]);
					check_field("timer_stop_id", want.timer_stop_id, m_tdata[76:74]);
					check_field("pad", 64'd0, m_tdata[79:77]);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_sender_response(s_tuser, s_tdata[63:0], s_tdata[66:64], s_tdata[67],
					s_tdata[70:68], pred);
				expected_responses.push_back(pred);
			end
		end
		outstanding = expected_responses.size();
	end

endmodule

/* sim/tb.sv */
// Top of the sender testbench: clock, reset, event stimulus and response-side
// backpressure; the verdict comes from the failure count of swfr_checker.
// Depends on swfr_pkg, swfr_checker and sliding_window_fast_retransmit_sender_core.
`timescale 1ns / 1ps

module tb;

	// func value that the block must ignore
	localparam logic [1:0] FUNC_UNDEFINED = 2'd3;
	localparam int EVENT_TARGET = 1350;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic [swfr_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic [swfr_pkg::S_TUSER_W-1:0] s_tuser  = '0;
	logic                           m_tready = 1'b0;
	logic                           s_tready;
	logic                           m_tvalid;
	logic [swfr_pkg::M_TDATA_W-1:0] m_tdata;

	int fail_count, outstanding, checked_count, refused_count, fast_resend_count;
	int n_send, n_ack, n_timeout, n_ignored;
	bit steady_feed;

	sliding_window_fast_retransmit_sender_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	swfr_checker chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.fail_count       (fail_count),
		.outstanding      (outstanding),
		.checked_count    (checked_count),
		.refused_count    (refused_count),
		.fast_resend_count(fast_resend_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop in case the handshake hangs
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Mostly back-to-back words, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_feed || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [63:0] rand_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return '0;
		if (r < 8)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Present one event word and hold it until the block takes it
	task automatic put_event(input logic [1:0] fn, input logic [63:0] pay,
			input logic [2:0] ack, input logic ok, input logic [2:0] exp_id);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {1'b0, exp_id, ok, ack, pay};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (fn == FUNC_UNDEFINED || (fn == swfr_pkg::FUNC_ACK && !ok))
			n_ignored++;
		else if (fn == swfr_pkg::FUNC_SEND)
			n_send++;
		else if (fn == swfr_pkg::FUNC_ACK)
			n_ack++;
		else
			n_timeout++;
	endtask

	// One edge first so the checker has counted the last word taken
	task automatic drain_responses();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	// Response-side backpressure: ready stretches of mixed length, rare long stalls
	initial begin
		int r, len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				m_tready <= 1'b1;
				len = (r < 8) ? $urandom_range(40, 150) : $urandom_range(1, 12);
			end else begin
				m_tready <= 1'b0;
				len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	initial begin
		int kind, reps;
		bit paused_mid;
		logic [2:0] ack;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: timeout on an empty window right after reset
		put_event(swfr_pkg::FUNC_TIMEOUT, '0, '0, 1'b0, 3'd7);
		// fill the window with extreme payloads, then one refused send
		put_event(swfr_pkg::FUNC_SEND, 64'h0, 3'd7, 1'b1, 3'd7);
		put_event(swfr_pkg::FUNC_SEND, '1, 3'd0, 1'b0, 3'd0);
		put_event(swfr_pkg::FUNC_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd5, 1'b1, 3'd2);
		put_event(swfr_pkg::FUNC_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd2, 1'b0, 3'd5);
		put_event(swfr_pkg::FUNC_SEND, 64'h0123_4567_89AB_CDEF, '1, 1'b1, '1);
		// bad checksum is dropped
		put_event(swfr_pkg::FUNC_ACK, '1, 3'd1, 1'b0, '1);
		// in-window ack, then duplicates up to fast retransmit and saturation
		put_event(swfr_pkg::FUNC_ACK, '0, 3'd1, 1'b1, '0);
		repeat (8) put_event(swfr_pkg::FUNC_ACK, rand_payload(), 3'd1, 1'b1, 3'd0);
		// timeout with outstanding packets
		put_event(swfr_pkg::FUNC_TIMEOUT, '1, 3'd4, 1'b1, 3'd5);
		// ack drains the window and stops the timer
		put_event(swfr_pkg::FUNC_ACK, '0, 3'd3, 1'b1, '0);
		// ack for an unsent number still inside the window
		put_event(swfr_pkg::FUNC_ACK, '0, 3'd5, 1'b1, '0);
		put_event(FUNC_UNDEFINED, '1, '1, 1'b1, '1);
		put_event(swfr_pkg::FUNC_TIMEOUT, '0, '0, 1'b0, 3'd0);
		put_event(swfr_pkg::FUNC_SEND, '1, '1, 1'b1, '1);
		drain_responses();

		// Random sequences until enough event words have gone in
		paused_mid = 1'b0;
		while (n_send + n_ack + n_timeout + n_ignored < EVENT_TARGET) begin
			if ($urandom_range(0, 99) < 4)
				steady_feed = !steady_feed;
			if (!paused_mid &&
					n_send + n_ack + n_timeout + n_ignored >= EVENT_TARGET / 2) begin
				drain_responses();
				paused_mid = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				// burst of sends, often past a full window
				reps = $urandom_range(1, 6);
				repeat (reps)
					put_event(swfr_pkg::FUNC_SEND, rand_payload(), 3'($urandom),
						1'($urandom), 3'($urandom));
			end else if (kind < 65) begin
				// cumulative ack followed by duplicates of it
				ack = 3'($urandom);
				reps = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 8);
				repeat (reps + 1)
					put_event(swfr_pkg::FUNC_ACK, rand_payload(), ack, 1'b1, 3'($urandom));
			end else if (kind < 80) begin
				put_event(swfr_pkg::FUNC_TIMEOUT, rand_payload(), 3'($urandom),
					1'($urandom), 3'($urandom));
			end else if (kind < 90) begin
				put_event(swfr_pkg::FUNC_ACK, rand_payload(), 3'($urandom),
					1'($urandom), 3'($urandom));
			end else if (kind < 95) begin
				put_event(swfr_pkg::FUNC_ACK, rand_payload(), 3'($urandom), 1'b0,
					3'($urandom));
			end else begin
				put_event(FUNC_UNDEFINED, rand_payload(), 3'($urandom), 1'($urandom),
					3'($urandom));
			end
		end

		drain_responses();
		repeat (8) @(posedge clk);

		$display("Events: %0d sends (%0d refused), %0d acks, %0d timeouts, %0d ignored",
			n_send, refused_count, n_ack, n_timeout, n_ignored);
		$display("Responses checked: %0d, fast retransmits: %0d",
			checked_count, fast_resend_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
hdl/swfr_pkg.sv
hdl/swfr_engine.sv
hdl/sliding_window_fast_retransmit_sender_core.sv
sim/swfr_checker.sv
sim/tb.sv
